### rtl/lcdnw_pkg.sv
// ----------------------------------------------------------------------------
// lcdnw_pkg: shared types, constants and microprogram
// Control word layout, action codes, hold times and the microcode table
// of the 4-bit character LCD write sequencer.
// ----------------------------------------------------------------------------
package lcdnw_pkg;

	localparam int STEP_W = 4;
	localparam int CNT_W  = 3;
	localparam int HOLD_W = 18;

	typedef logic [STEP_W-1:0] step_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [HOLD_W-1:0] hold_t;

	typedef enum logic [2:0] {
		ACT_INIT  = 3'd0,
		ACT_CMD   = 3'd1,
		ACT_DATA  = 3'd2,
		ACT_POS   = 3'd3,
		ACT_CLEAR = 3'd4
	} action_t;

	typedef enum logic {
		SRC_INIT = 1'b0,
		SRC_REG  = 1'b1
	} src_t;

	typedef enum logic [1:0] {
		NIB_HI   = 2'd0,
		NIB_LO   = 2'd1,
		NIB_ZERO = 2'd2
	} nib_sel_t;

	typedef enum logic [2:0] {
		HSEL_EN    = 3'd0,
		HSEL_MID   = 3'd1,
		HSEL_END   = 3'd2,
		HSEL_FINAL = 3'd3,
		HSEL_POWER = 3'd4
	} hold_sel_t;

	typedef enum logic [1:0] {
		SEQ_NEXT = 2'd0,
		SEQ_LOOP = 2'd1,
		SEQ_END  = 2'd2
	} seq_t;

	typedef struct packed {
		src_t      src;
		nib_sel_t  nib;
		logic      en;
		hold_sel_t hold;
		seq_t      seq;
		step_t     target;
	} ctrl_t;

	localparam hold_t HOLD_EN_HIGH   = 18'd1;
	localparam hold_t HOLD_MID       = 18'd100;
	localparam hold_t HOLD_END       = 18'd2000;
	localparam hold_t HOLD_CLEAR_END = 18'd4000;
	localparam hold_t HOLD_POWER_UP  = 18'd200000;

	localparam logic [7:0] CMD_CLEAR   = 8'h01;
	localparam logic [3:0] DDRAM_ROW0  = 4'h8;
	localparam logic [3:0] DDRAM_ROW1  = 4'hC;

	// entry points and extent of the microprogram
	localparam step_t STEP_INIT      = 4'd0;
	localparam step_t STEP_INIT_BYTE = 4'd1;
	localparam step_t STEP_BYTE      = 4'd5;
	localparam step_t STEP_LAST      = 4'd8;
	localparam cnt_t  INIT_LAST      = 3'd5;

	function automatic logic [7:0] init_cmd(input cnt_t idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h33;
			3'd1: c = 8'h32;
			3'd2: c = 8'h28;
			3'd3: c = 8'h0C;
			3'd4: c = 8'h01;
			3'd5: c = 8'h82;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic ctrl_t ucode(input step_t s);
		ctrl_t w;
		case (s)
			// power-up wait
			4'd0: w = '{SRC_INIT, NIB_ZERO, 1'b0, HSEL_POWER, SEQ_NEXT, 4'd0};
			// init command loop
			4'd1: w = '{SRC_INIT, NIB_HI,   1'b1, HSEL_EN,    SEQ_NEXT, 4'd0};
			4'd2: w = '{SRC_INIT, NIB_HI,   1'b0, HSEL_MID,   SEQ_NEXT, 4'd0};
			4'd3: w = '{SRC_INIT, NIB_LO,   1'b1, HSEL_EN,    SEQ_NEXT, 4'd0};
			4'd4: w = '{SRC_INIT, NIB_LO,   1'b0, HSEL_END,   SEQ_LOOP, STEP_INIT_BYTE};
			// single byte from the latched request
			4'd5: w = '{SRC_REG,  NIB_HI,   1'b1, HSEL_EN,    SEQ_NEXT, 4'd0};
			4'd6: w = '{SRC_REG,  NIB_HI,   1'b0, HSEL_MID,   SEQ_NEXT, 4'd0};
			4'd7: w = '{SRC_REG,  NIB_LO,   1'b1, HSEL_EN,    SEQ_NEXT, 4'd0};
			4'd8: w = '{SRC_REG,  NIB_LO,   1'b0, HSEL_FINAL, SEQ_END,  4'd0};
			default: w = '{SRC_REG, NIB_ZERO, 1'b0, HSEL_EN, SEQ_END, 4'd0};
		endcase
		return w;
	endfunction

endpackage

### rtl/lcdnw_urom.sv
// ----------------------------------------------------------------------------
// lcdnw_urom: microcode store
// Read-only control store, one control word per program step.
// ----------------------------------------------------------------------------
module lcdnw_urom (
	input  lcdnw_pkg::step_t step,
	output lcdnw_pkg::ctrl_t ctrl
);

	always_comb begin
		ctrl = lcdnw_pkg::ucode(step);
	end

endmodule

### rtl/lcdnw_datapath.sv
// ----------------------------------------------------------------------------
// lcdnw_datapath: byte latch, nibble and hold selection, phase register
// Latches the byte of a request, then builds each bus phase from the
// control word and registers it for the output stream.
// ----------------------------------------------------------------------------
module lcdnw_datapath (
	input  logic             clk,
	input  logic             accept,
	input  logic [2:0]       action,
	input  logic [7:0]       byte_value,
	input  logic [1:0]       row,
	input  logic [4:0]       column,
	input  logic             load,
	input  lcdnw_pkg::ctrl_t ctrl,
	input  lcdnw_pkg::cnt_t  cnt,
	input  logic             last,
	output logic [3:0]       data_nibble,
	output logic             register_select,
	output logic             enable_level,
	output lcdnw_pkg::hold_t hold_us,
	output logic             last_phase
);

	logic [7:0]       byte_q;
	logic             rs_q;
	logic             clear_q;
	logic [7:0]       cur_byte;
	logic [3:0]       nib;
	lcdnw_pkg::hold_t hold;
	logic [3:0]       nib_q;
	logic             rs_out_q;
	logic             en_q;
	lcdnw_pkg::hold_t hold_q;
	logic             last_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			rs_q    <= 1'b0;
			clear_q <= 1'b0;
			case (action)
				lcdnw_pkg::ACT_CMD: begin
					byte_q <= byte_value;
				end
				lcdnw_pkg::ACT_DATA: begin
					byte_q <= byte_value;
					rs_q   <= 1'b1;
				end
				lcdnw_pkg::ACT_POS: begin
					byte_q <= {(row[0] ? lcdnw_pkg::DDRAM_ROW1 : lcdnw_pkg::DDRAM_ROW0),
						column[3:0]};
				end
				lcdnw_pkg::ACT_CLEAR: begin
					byte_q  <= lcdnw_pkg::CMD_CLEAR;
					clear_q <= 1'b1;
				end
				default: begin
					byte_q <= byte_value;
				end
			endcase
		end
	end

	always_comb begin
		cur_byte = (ctrl.src == lcdnw_pkg::SRC_INIT) ? lcdnw_pkg::init_cmd(cnt) : byte_q;
		case (ctrl.nib)
			lcdnw_pkg::NIB_HI: nib = cur_byte[7:4];
			lcdnw_pkg::NIB_LO: nib = cur_byte[3:0];
			default:           nib = 4'h0;
		endcase
		case (ctrl.hold)
			lcdnw_pkg::HSEL_EN:    hold = lcdnw_pkg::HOLD_EN_HIGH;
			lcdnw_pkg::HSEL_MID:   hold = lcdnw_pkg::HOLD_MID;
			lcdnw_pkg::HSEL_END:   hold = lcdnw_pkg::HOLD_END;
			lcdnw_pkg::HSEL_FINAL: hold = clear_q ? lcdnw_pkg::HOLD_CLEAR_END
				: lcdnw_pkg::HOLD_END;
			lcdnw_pkg::HSEL_POWER: hold = lcdnw_pkg::HOLD_POWER_UP;
			default:               hold = lcdnw_pkg::HOLD_END;
		endcase
	end

	// init phases always go to the command register
	always_ff @(posedge clk) begin
		if (load) begin
			nib_q    <= nib;
			rs_out_q <= (ctrl.src == lcdnw_pkg::SRC_REG) ? rs_q : 1'b0;
			en_q     <= ctrl.en;
			hold_q   <= hold;
			last_q   <= last;
		end
	end

	assign data_nibble     = nib_q;
	assign register_select = rs_out_q;
	assign enable_level    = en_q;
	assign hold_us         = hold_q;
	assign last_phase      = last_q;

endmodule

### rtl/char_lcd_nibble_write_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer: 4-bit character LCD write sequencer
// Turns LCD requests into enable/data bus phases with hold times, driven
// by a microprogram with a step counter and an init command loop.
//
//  channel | dir | tdata (low bit up)                      | tuser           | tlast
//  s_*     | in  | action[2:0] byte_value[7:0] row[1:0]    | -               | -
//          |     | column[4:0], 6 zero bits                |                 |
//  m_*     | out | data_nibble[3:0] enable_level hold_us   | register_select | last
//          |     | [17:0], 1 zero bit                      |                 |
//
// one phase per cycle from the microcode step counter while m_tready is high;
// a byte request gives 4 phases, an init request 25, ignored ones none
// the next request is taken as soon as the final phase sits in the output reg
// a stalled output holds the step counter and the phase register
// reset clears the busy flag, step and loop counters and the output valid
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // action, byte_value, row, column
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // data_nibble, enable_level, hold_us
	output logic        m_tuser,   // register_select
	output logic        m_tlast
);

	logic [2:0]       action;
	logic [7:0]       byte_value;
	logic [1:0]       row;
	logic [4:0]       column;
	logic             accept;
	logic             busy_q;
	lcdnw_pkg::step_t step_q;
	lcdnw_pkg::cnt_t  cnt_q;
	logic             valid_q;
	lcdnw_pkg::ctrl_t ctrl;
	logic             load;
	logic             phase_last;
	logic             start;
	lcdnw_pkg::step_t entry;
	logic [3:0]       data_nibble;
	logic             register_select;
	logic             enable_level;
	lcdnw_pkg::hold_t hold_us;
	logic             last_phase;

	assign action     = s_tdata[2:0];
	assign byte_value = s_tdata[10:3];
	assign row        = s_tdata[12:11];
	assign column     = s_tdata[17:13];

	assign s_tready = !busy_q;
	assign accept   = s_tvalid && s_tready;
	assign load     = busy_q && (!valid_q || m_tready);

	always_comb begin
		start = 1'b1;
		entry = lcdnw_pkg::STEP_BYTE;
		case (action)
			lcdnw_pkg::ACT_INIT:  entry = lcdnw_pkg::STEP_INIT;
			lcdnw_pkg::ACT_CMD,
			lcdnw_pkg::ACT_DATA,
			lcdnw_pkg::ACT_CLEAR: entry = lcdnw_pkg::STEP_BYTE;
			// off-screen positions send nothing
			lcdnw_pkg::ACT_POS:   start = !column[4] && !row[1];
			default:              start = 1'b0;
		endcase
	end

	assign phase_last = (ctrl.seq == lcdnw_pkg::SEQ_END)
		|| (ctrl.seq == lcdnw_pkg::SEQ_LOOP && cnt_q == lcdnw_pkg::INIT_LAST);

	lcdnw_urom u_urom (
		.step (step_q),
		.ctrl (ctrl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			cnt_q  <= '0;
		end else if (accept) begin
			busy_q <= start;
			step_q <= entry;
			cnt_q  <= '0;
		end else if (load) begin
			if (phase_last) begin
				busy_q <= 1'b0;
			end else if (ctrl.seq == lcdnw_pkg::SEQ_LOOP) begin
				step_q <= ctrl.target;
				cnt_q  <= cnt_q + 3'd1;
			end else begin
				step_q <= step_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	lcdnw_datapath u_datapath (
		.clk             (clk),
		.accept          (accept),
		.action          (action),
		.byte_value      (byte_value),
		.row             (row),
		.column          (column),
		.load            (load),
		.ctrl            (ctrl),
		.cnt             (cnt_q),
		.last            (phase_last),
		.data_nibble     (data_nibble),
		.register_select (register_select),
		.enable_level    (enable_level),
		.hold_us         (hold_us),
		.last_phase      (last_phase)
	);

	assign m_tvalid = valid_q;
	assign m_tdata  = {1'b0, hold_us, enable_level, data_nibble};
	assign m_tuser  = register_select;
	assign m_tlast  = last_phase;

`ifndef ASSERT_OFF
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> step_q <= lcdnw_pkg::STEP_LAST)
		else $error("microcode step beyond program");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= lcdnw_pkg::INIT_LAST)
		else $error("init loop count beyond command list");

	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(load && phase_last) |=> !busy_q)
		else $error("sequencer still busy after final phase");

	a_last_out: assert property (@(posedge clk) disable iff (!arst_n)
		(load && phase_last) |=> (m_tvalid && m_tlast))
		else $error("final phase not flagged on output");
`endif

endmodule
